// ===== src/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU set-associative cache lookup: shared package
// Default sizes, configuration register indexes, outcome codes, sequencer
// states and the status bundle between the lookup engine and the top level.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAX_SETS_DEF  = 64;
    localparam int MAX_WAYS_DEF  = 8;
    localparam int ADDR_BITS_DEF = 64;

    // Width of the address field on the port.
    localparam int ADDR_FIELD_W = 64;
    localparam int CNT_TOTAL_W  = 32;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [2:0] SET_BITS_RST    = 3'd1;
    localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_RST        = 4'd1;

    localparam logic [CNT_TOTAL_W-1:0] CNT_SAT = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_WRITE,
        ST_REPORT
    } lsc_state_t;

    typedef struct packed {
        logic     busy;
        logic     done;
        outcome_t outcome;
    } lsc_status_t;

endpackage

// ===== src/lsc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lsc_split.sv =====
// ----------------------------------------------------------------------------
// Address split
// Applies the configured field sizes to an address and registers the tag,
// the set index and the effective way count for the lookup engine.
// ----------------------------------------------------------------------------
module lsc_split #(
    parameter int MAX_SETS  = lsc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = lsc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = lsc_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic [lsc_pkg::ADDR_FIELD_W-1:0]  address,
    input  logic [2:0]                        set_index_bits,
    input  logic [4:0]                        block_offset_bits,
    input  logic [3:0]                        ways_in_use,
    output logic [ADDR_BITS-3:0]              tag,
    output logic [$clog2(MAX_SETS)-1:0]       set_idx,
    output logic [$clog2(MAX_WAYS+1)-1:0]     ways
);

    localparam int TAG_W = ADDR_BITS - 2;
    localparam int SET_W = $clog2(MAX_SETS);
    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    // Largest usable set-bit count: floor(log2(MAX_SETS)).
    localparam int SMAX = $clog2(MAX_SETS + 1) - 1;
    localparam logic [3:0] SMAX_V = 4'(SMAX);
    localparam logic [4:0] MAXW_V = 5'(MAX_WAYS);

    logic [3:0]           s_eff;
    logic [4:0]           b_eff;
    logic [4:0]           w_eff;
    logic [5:0]           shamt;
    logic [ADDR_BITS-1:0] addr_use;
    logic [ADDR_BITS-1:0] tag_shift;
    logic [ADDR_BITS-1:0] set_shift;
    logic [TAG_W-1:0]     tag_c;
    logic [SET_W-1:0]     set_c;

    logic [TAG_W-1:0]     tag_reg;
    logic [SET_W-1:0]     set_reg;
    logic [CNT_W-1:0]     ways_reg;

    always_comb
    begin
        s_eff = {1'b0, set_index_bits};
        if (s_eff == 4'd0)
        begin
            s_eff = 4'd1;
        end
        if (s_eff > SMAX_V)
        begin
            s_eff = SMAX_V;
        end

        b_eff = block_offset_bits;
        if (b_eff == 5'd0)
        begin
            b_eff = 5'd1;
        end

        w_eff = {1'b0, ways_in_use};
        if (w_eff == 5'd0)
        begin
            w_eff = 5'd1;
        end
        if (w_eff > MAXW_V)
        begin
            w_eff = MAXW_V;
        end

        shamt     = 6'(s_eff) + 6'(b_eff);
        addr_use  = address[ADDR_BITS-1:0];
        tag_shift = addr_use >> shamt;
        set_shift = addr_use >> b_eff;
        // The shift is at least two, so the top two bits are always zero.
        tag_c     = tag_shift[TAG_W-1:0];
        for (int i = 0; i < SET_W; i++)
        begin
            set_c[i] = set_shift[i] & (i < int'(s_eff));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg  <= tag_c;
            set_reg  <= set_c;
            ways_reg <= CNT_W'(w_eff);
        end
    end

    assign tag     = tag_reg;
    assign set_idx = set_reg;
    assign ways    = ways_reg;

endmodule

// ===== src/lsc_engine.sv =====
// ----------------------------------------------------------------------------
// Lookup engine
// Reads one set row into a working register, walks its ways one per cycle
// through a single tag and rank comparator, walks them again to age the
// recency ranks, and writes the row back.
// ----------------------------------------------------------------------------
module lsc_engine #(
    parameter int MAX_SETS  = lsc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = lsc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = lsc_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ADDR_BITS-3:0]          tag,
    input  logic [$clog2(MAX_SETS)-1:0]   set_idx,
    input  logic [$clog2(MAX_WAYS+1)-1:0] ways,
    input  logic                          out_free,
    output lsc_pkg::lsc_status_t          status
);

    localparam int TAG_W  = ADDR_BITS - 2;
    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int LINE_W = 1 + RANK_W + TAG_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(MAX_WAYS - 1);

    lsc_pkg::lsc_state_t state_reg, state_next;
    logic [WAY_W-1:0]    idx_reg, idx_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic                old_valid_reg, old_valid_next;
    logic [RANK_W-1:0]   old_rank_reg, old_rank_next;
    logic                inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]    inv_way_reg, inv_way_next;
    logic [RANK_W-1:0]   max_rank_reg, max_rank_next;
    logic [WAY_W-1:0]    vict_way_reg, vict_way_next;
    lsc_pkg::outcome_t   outcome_reg, outcome_next;
    logic [MAX_SETS-1:0] row_written_reg, row_written_next;

    logic                line_valid_reg [MAX_WAYS];
    logic                line_valid_next [MAX_WAYS];
    logic [RANK_W-1:0]   line_rank_reg [MAX_WAYS];
    logic [RANK_W-1:0]   line_rank_next [MAX_WAYS];
    logic [TAG_W-1:0]    line_tag_reg [MAX_WAYS];
    logic [TAG_W-1:0]    line_tag_next [MAX_WAYS];

    logic                rd_en;
    logic                wr_en;
    logic [ROW_W-1:0]    rd_data;
    logic [ROW_W-1:0]    wr_data;

    logic                cur_valid;
    logic [RANK_W-1:0]   cur_rank;
    logic [TAG_W-1:0]    cur_tag;
    logic                scan_last;
    logic                inv_now;
    logic [WAY_W-1:0]    inv_way_now;
    logic                take_max;
    logic [RANK_W-1:0]   max_rank_now;
    logic [WAY_W-1:0]    vict_way_now;

    lsc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (set_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (set_idx),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            wr_data[w*LINE_W +: LINE_W] = {line_valid_reg[w], line_rank_reg[w], line_tag_reg[w]};
        end
    end

    // The shared comparator: one way of the working row per cycle.
    always_comb
    begin
        cur_valid    = line_valid_reg[idx_reg];
        cur_rank     = line_rank_reg[idx_reg];
        cur_tag      = line_tag_reg[idx_reg];
        scan_last    = (CNT_W'(idx_reg) + CNT_W'(1)) == ways;
        inv_now      = inv_found_reg | ~cur_valid;
        inv_way_now  = (!inv_found_reg && !cur_valid) ? idx_reg : inv_way_reg;
        take_max     = (idx_reg == '0) || (cur_rank > max_rank_reg);
        max_rank_now = take_max ? cur_rank : max_rank_reg;
        vict_way_now = take_max ? idx_reg : vict_way_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        way_next         = way_reg;
        old_valid_next   = old_valid_reg;
        old_rank_next    = old_rank_reg;
        inv_found_next   = inv_found_reg;
        inv_way_next     = inv_way_reg;
        max_rank_next    = max_rank_reg;
        vict_way_next    = vict_way_reg;
        outcome_next     = outcome_reg;
        row_written_next = row_written_reg;
        line_valid_next  = line_valid_reg;
        line_rank_next   = line_rank_reg;
        line_tag_next    = line_tag_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        status.busy      = (state_reg != lsc_pkg::ST_IDLE);
        status.done      = 1'b0;
        status.outcome   = outcome_reg;

        unique case (state_reg)
            lsc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lsc_pkg::ST_READ;
                end
            end
            lsc_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = lsc_pkg::ST_LOAD;
            end
            lsc_pkg::ST_LOAD:
            begin
                // A row never written since reset reads as all zero.
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    if (row_written_reg[set_idx])
                    begin
                        {line_valid_next[w], line_rank_next[w], line_tag_next[w]} =
                            rd_data[w*LINE_W +: LINE_W];
                    end
                    else
                    begin
                        line_valid_next[w] = 1'b0;
                        line_rank_next[w]  = '0;
                        line_tag_next[w]   = '0;
                    end
                end
                idx_next       = '0;
                inv_found_next = 1'b0;
                state_next     = lsc_pkg::ST_SCAN;
            end
            lsc_pkg::ST_SCAN:
            begin
                inv_found_next = inv_now;
                inv_way_next   = inv_way_now;
                max_rank_next  = max_rank_now;
                vict_way_next  = vict_way_now;
                idx_next       = idx_reg + WAY_W'(1);
                if (cur_valid && (cur_tag == tag))
                begin
                    way_next       = idx_reg;
                    old_valid_next = 1'b1;
                    old_rank_next  = cur_rank;
                    outcome_next   = lsc_pkg::OUT_HIT;
                    idx_next       = '0;
                    state_next     = lsc_pkg::ST_UPDATE;
                end
                else if (scan_last)
                begin
                    idx_next   = '0;
                    state_next = lsc_pkg::ST_UPDATE;
                    if (inv_now)
                    begin
                        way_next       = inv_way_now;
                        old_valid_next = 1'b0;
                        outcome_next   = lsc_pkg::OUT_FILL;
                    end
                    else
                    begin
                        way_next       = vict_way_now;
                        old_valid_next = 1'b1;
                        old_rank_next  = max_rank_now;
                        outcome_next   = lsc_pkg::OUT_EVICT;
                    end
                end
            end
            lsc_pkg::ST_UPDATE:
            begin
                // Lines that were more recent than the touched one age by one;
                // a fresh fill ages every valid line.
                if (idx_reg == way_reg)
                begin
                    line_valid_next[idx_reg] = 1'b1;
                    line_rank_next[idx_reg]  = '0;
                    line_tag_next[idx_reg]   = tag;
                end
                else if (cur_valid && (!old_valid_reg || (cur_rank < old_rank_reg)))
                begin
                    line_rank_next[idx_reg] = cur_rank + RANK_W'(1);
                end
                idx_next = idx_reg + WAY_W'(1);
                if (idx_reg == LAST_WAY)
                begin
                    idx_next   = '0;
                    state_next = lsc_pkg::ST_WRITE;
                end
            end
            lsc_pkg::ST_WRITE:
            begin
                wr_en                     = 1'b1;
                row_written_next[set_idx] = 1'b1;
                state_next                = lsc_pkg::ST_REPORT;
            end
            lsc_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    status.done = 1'b1;
                    state_next  = lsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lsc_pkg::ST_IDLE;
            row_written_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            row_written_reg <= row_written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        way_reg        <= way_next;
        old_valid_reg  <= old_valid_next;
        old_rank_reg   <= old_rank_next;
        inv_found_reg  <= inv_found_next;
        inv_way_reg    <= inv_way_next;
        max_rank_reg   <= max_rank_next;
        vict_way_reg   <= vict_way_next;
        outcome_reg    <= outcome_next;
        line_valid_reg <= line_valid_next;
        line_rank_reg  <= line_rank_next;
        line_tag_reg   <= line_tag_next;
    end

endmodule

// ===== src/lru_set_assoc_cache_lookup_top.sv =====
// ----------------------------------------------------------------------------
// LRU set-associative cache lookup: top level
// Configuration registers, hit/miss/eviction totals and the result register.
// ----------------------------------------------------------------------------
// Each address transaction is looked up in one set of a cache model of
// MAX_SETS rows by MAX_WAYS ways and answered with one result transaction:
// hit, miss that fills an invalid way, or miss that evicts the least recently
// used way, together with the saturating totals after that access. From
// acceptance to result, the split registers the address fields, the row
// of the set is read, a single comparator walks the ways of the set once
// for the lookup (up to ways_in_use, fewer on an early hit) and once over
// all MAX_WAYS ways to age the recency ranks, and the row is written back
// to the set memory. A new address is taken as soon as the previous one
// has left the engine, even while its result is still waiting.
// All contents are empty after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_lookup_top #(
    parameter int MAX_SETS  = lsc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = lsc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = lsc_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               address_valid,
    output logic                               address_stall,
    input  logic [lsc_pkg::ADDR_FIELD_W-1:0]   address,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [1:0]                         outcome,
    output logic [lsc_pkg::CNT_TOTAL_W-1:0]    hit_total,
    output logic [lsc_pkg::CNT_TOTAL_W-1:0]    miss_total,
    output logic [lsc_pkg::CNT_TOTAL_W-1:0]    eviction_total
);

    localparam int TAG_W = ADDR_BITS - 2;
    localparam int SET_W = $clog2(MAX_SETS);
    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    localparam int TOT_W = lsc_pkg::CNT_TOTAL_W;

    logic [2:0]       set_bits_reg, set_bits_next;
    logic [4:0]       offset_bits_reg, offset_bits_next;
    logic [3:0]       ways_cfg_reg, ways_cfg_next;
    logic [TOT_W-1:0] hit_reg, hit_next;
    logic [TOT_W-1:0] miss_reg, miss_next;
    logic [TOT_W-1:0] evict_reg, evict_next;
    logic             result_valid_reg, result_valid_next;
    lsc_pkg::outcome_t outcome_reg, outcome_next;

    logic                 accept;
    logic                 out_free;
    logic [TAG_W-1:0]     tag;
    logic [SET_W-1:0]     set_idx;
    logic [CNT_W-1:0]     ways;
    lsc_pkg::lsc_status_t status;

    assign cfg_ready     = 1'b1;
    assign address_stall = status.busy;
    assign accept        = address_valid & ~address_stall;
    assign out_free      = ~result_valid_reg | ~result_stall;

    lsc_split #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_split (
        .clk               (clk),
        .load              (accept),
        .address           (address),
        .set_index_bits    (set_bits_reg),
        .block_offset_bits (offset_bits_reg),
        .ways_in_use       (ways_cfg_reg),
        .tag               (tag),
        .set_idx           (set_idx),
        .ways              (ways)
    );

    lsc_engine #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .tag      (tag),
        .set_idx  (set_idx),
        .ways     (ways),
        .out_free (out_free),
        .status   (status)
    );

    always_comb
    begin
        set_bits_next    = set_bits_reg;
        offset_bits_next = offset_bits_reg;
        ways_cfg_next    = ways_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lsc_pkg::CFG_SET_BITS:    set_bits_next    = cfg_data[2:0];
                lsc_pkg::CFG_OFFSET_BITS: offset_bits_next = cfg_data[4:0];
                lsc_pkg::CFG_WAYS:        ways_cfg_next    = cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    // The totals double as the result payload; they only move when the
    // result register is free or being emptied.
    always_comb
    begin
        hit_next          = hit_reg;
        miss_next         = miss_reg;
        evict_next        = evict_reg;
        outcome_next      = outcome_reg;
        result_valid_next = result_valid_reg & result_stall;
        if (status.done)
        begin
            result_valid_next = 1'b1;
            outcome_next      = status.outcome;
            if (status.outcome == lsc_pkg::OUT_HIT)
            begin
                if (hit_reg != lsc_pkg::CNT_SAT)
                begin
                    hit_next = hit_reg + TOT_W'(1);
                end
            end
            else
            begin
                if (miss_reg != lsc_pkg::CNT_SAT)
                begin
                    miss_next = miss_reg + TOT_W'(1);
                end
                if ((status.outcome == lsc_pkg::OUT_EVICT) && (evict_reg != lsc_pkg::CNT_SAT))
                begin
                    evict_next = evict_reg + TOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg     <= lsc_pkg::SET_BITS_RST;
            offset_bits_reg  <= lsc_pkg::OFFSET_BITS_RST;
            ways_cfg_reg     <= lsc_pkg::WAYS_RST;
            hit_reg          <= '0;
            miss_reg         <= '0;
            evict_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            set_bits_reg     <= set_bits_next;
            offset_bits_reg  <= offset_bits_next;
            ways_cfg_reg     <= ways_cfg_next;
            hit_reg          <= hit_next;
            miss_reg         <= miss_next;
            evict_reg        <= evict_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
    end

    assign result_valid   = result_valid_reg;
    assign outcome        = outcome_reg;
    assign hit_total      = hit_reg;
    assign miss_total     = miss_reg;
    assign eviction_total = evict_reg;

endmodule

// ===== src/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// LRU set-associative cache lookup: port checker
// Watches the top-level ports and is attached to every instance by bind.
// ----------------------------------------------------------------------------
module lsc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [lsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input logic [lsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input logic                               address_valid,
    input logic                               address_stall,
    input logic [lsc_pkg::ADDR_FIELD_W-1:0]   address,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [1:0]                         outcome,
    input logic [lsc_pkg::CNT_TOTAL_W-1:0]    hit_total,
    input logic [lsc_pkg::CNT_TOTAL_W-1:0]    miss_total,
    input logic [lsc_pkg::CNT_TOTAL_W-1:0]    eviction_total
);

    // An accepted address moves the engine out of idle, so it always blocks
    // the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        address_valid && !address_stall |=> address_stall)
        else $error("address accepted on two consecutive cycles");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(outcome)
            && $stable(hit_total) && $stable(miss_total) && $stable(eviction_total))
        else $error("stalled result transaction changed");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (outcome == lsc_pkg::OUT_HIT) |-> hit_total != '0)
        else $error("hit reported with zero hit total");

    a_evict_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (outcome == lsc_pkg::OUT_EVICT) |-> eviction_total != '0)
        else $error("eviction reported with zero eviction total");

    // Every eviction is also a miss.
    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> eviction_total <= miss_total)
        else $error("eviction total exceeds miss total");

endmodule

bind lru_set_assoc_cache_lookup_top lsc_checker u_lsc_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU set-associative cache lookup: testbench
// Drives address transactions through several cache geometries, predicts the
// hit, fill or eviction outcome and the running totals of each lookup, and
// checks every result transaction in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LINE_COUNT    = lsc_pkg::MAX_SETS_DEF * lsc_pkg::MAX_WAYS_DEF;
    localparam int SET_BITS_MAX  = $clog2(lsc_pkg::MAX_SETS_DEF);
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_DEPTH    = 16;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [lsc_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        lsc_pkg::outcome_t             outcome;
        bit [lsc_pkg::CNT_TOTAL_W-1:0] hits;
        bit [lsc_pkg::CNT_TOTAL_W-1:0] misses;
        bit [lsc_pkg::CNT_TOTAL_W-1:0] evictions;
    } lookup_result_t;

    class lookup_scoreboard;
        bit [2:0]                      set_bits    = lsc_pkg::SET_BITS_RST;
        bit [4:0]                      offset_bits = lsc_pkg::OFFSET_BITS_RST;
        bit [3:0]                      ways        = lsc_pkg::WAYS_RST;
        bit                            line_valid [LINE_COUNT];
        bit [63:0]                     line_tag   [LINE_COUNT];
        int unsigned                   line_rank  [LINE_COUNT];
        bit [lsc_pkg::CNT_TOTAL_W-1:0] hits;
        bit [lsc_pkg::CNT_TOTAL_W-1:0] misses;
        bit [lsc_pkg::CNT_TOTAL_W-1:0] evictions;
        lookup_result_t                pending_lookups [$];
        int unsigned                   errors;

        function void write_reg(logic [lsc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lsc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lsc_pkg::CFG_SET_BITS:    set_bits    = data[2:0];
                lsc_pkg::CFG_OFFSET_BITS: offset_bits = data[4:0];
                lsc_pkg::CFG_WAYS:        ways        = data[3:0];
                default:                  ;
            endcase
        endfunction

        // Register values as the lookup actually uses them.
        function void eff_geometry(output int unsigned s, output int unsigned b,
                                   output int unsigned e);
            s = set_bits;
            if (s < 1) s = 1;
            if (s > SET_BITS_MAX) s = SET_BITS_MAX;
            b = offset_bits;
            if (b < 1) b = 1;
            e = ways;
            if (e < 1) e = 1;
            if (e > lsc_pkg::MAX_WAYS_DEF) e = lsc_pkg::MAX_WAYS_DEF;
        endfunction

        function bit [lsc_pkg::CNT_TOTAL_W-1:0] bump(bit [lsc_pkg::CNT_TOTAL_W-1:0] count);
            return (count == lsc_pkg::CNT_SAT) ? count : count + 1'b1;
        endfunction

        function void note_address(bit [63:0] addr);
            int unsigned    s, b, e, base, way, old, i;
            bit [63:0]      tag, set_no;
            bit             found;
            lookup_result_t r;
            eff_geometry(s, b, e);
            tag    = addr >> (s + b);
            set_no = (addr >> b) & ((64'd1 << s) - 64'd1);
            base   = 32'(set_no * lsc_pkg::MAX_WAYS_DEF);
            found  = 1'b0;
            way    = 0;
            for (i = 0; i < e; i++)
            begin
                if (!found && line_valid[base+i] && line_tag[base+i] == tag)
                begin
                    way   = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                r.outcome = lsc_pkg::OUT_HIT;
                hits      = bump(hits);
            end
            else
            begin
                misses = bump(misses);
                for (i = 0; i < e; i++)
                begin
                    if (!found && !line_valid[base+i])
                    begin
                        way   = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    r.outcome = lsc_pkg::OUT_FILL;
                end
                else
                begin
                    r.outcome = lsc_pkg::OUT_EVICT;
                    evictions = bump(evictions);
                    way       = 0;
                    for (i = 1; i < e; i++)
                    begin
                        if (line_rank[base+i] > line_rank[base+way]) way = i;
                    end
                end
            end
            // A fresh line ranks as older than every valid line, so all of them age.
            old = line_valid[base+way] ? line_rank[base+way] : 255;
            for (i = 0; i < lsc_pkg::MAX_WAYS_DEF; i++)
            begin
                if (i != way && line_valid[base+i] && line_rank[base+i] < old)
                    line_rank[base+i] = line_rank[base+i] + 1;
            end
            line_rank[base+way]  = 0;
            line_valid[base+way] = 1'b1;
            line_tag[base+way]   = tag;
            r.hits      = hits;
            r.misses    = misses;
            r.evictions = evictions;
            pending_lookups.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] oc, logic [31:0] h, logic [31:0] m,
                                   logic [31:0] ev);
            lookup_result_t r;
            if (pending_lookups.size() == 0)
            begin
                $error("result transaction with no lookup pending");
                errors++;
            end
            else
            begin
                r = pending_lookups.pop_front();
                compare("outcome", 32'(r.outcome), 32'(oc));
                compare("hit_total", r.hits, h);
                compare("miss_total", r.misses, m);
                compare("eviction_total", r.evictions, ev);
            end
        endfunction
    endclass

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [lsc_pkg::CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                             address_valid = 1'b0;
    logic                             address_stall;
    logic [lsc_pkg::ADDR_FIELD_W-1:0] address       = '0;
    logic                             result_valid;
    logic                             result_stall  = 1'b0;
    logic [1:0]                       outcome;
    logic [lsc_pkg::CNT_TOTAL_W-1:0]  hit_total;
    logic [lsc_pkg::CNT_TOTAL_W-1:0]  miss_total;
    logic [lsc_pkg::CNT_TOTAL_W-1:0]  eviction_total;

    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;

    lookup_scoreboard sb = new;

    lru_set_assoc_cache_lookup_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .address_valid  (address_valid),
        .address_stall  (address_stall),
        .address        (address),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .outcome        (outcome),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(outcome, hit_total, miss_total, eviction_total);
    end

    // Result-side back-pressure: random bursts, or one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Valid stays high after acceptance so back-to-back transactions need no
    // second assignment in the same step; end_stream drops it.
    task automatic send_address(input bit [63:0] a);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            address_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        address_valid <= 1'b1;
        address       <= a;
        @(posedge clk);
        while (address_stall) @(posedge clk);
        sb.note_address(a);
    endtask

    task automatic end_stream();
        address_valid <= 1'b0;
    endtask

    task automatic cfg_write(input logic [lsc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lsc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [lsc_pkg::CFG_DATA_W-1:0] set_val,
                             input logic [lsc_pkg::CFG_DATA_W-1:0] offset_val,
                             input logic [lsc_pkg::CFG_DATA_W-1:0] ways_val);
        cfg_write(lsc_pkg::CFG_WAYS, ways_val);
        cfg_write(lsc_pkg::CFG_OFFSET_BITS, offset_val);
        cfg_write(lsc_pkg::CFG_SET_BITS, set_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_lookups.size() != 0) @(posedge clk);
    endtask

    // Most addresses reuse a small pool of tags on a few hot sets so that hits,
    // fills and evictions all occur; the rest are fully random addresses.
    task automatic run_random(input int unsigned n_items);
        bit [63:0]   tag_pool [POOL_DEPTH];
        bit [63:0]   low_mask, set_mask, set_no, offs, a;
        int unsigned s, b, e, pool_n, hot, k;
        sb.eff_geometry(s, b, e);
        low_mask = (64'd1 << (s + b)) - 64'd1;
        set_mask = (64'd1 << s) - 64'd1;
        pool_n   = e + $urandom_range(1, 4);
        hot      = (set_mask < 3) ? 32'(set_mask) : 3;
        for (k = 0; k < POOL_DEPTH; k++) tag_pool[k] = rand64();
        for (k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                set_no = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, hot))
                                                     : (rand64() & set_mask);
                offs   = rand64() & ((64'd1 << b) - 64'd1);
                a      = (tag_pool[$urandom_range(0, pool_n - 1)] & ~low_mask)
                         | (set_no << b) | offs;
            end
            else
            begin
                a = rand64();
            end
            send_address(a);
        end
        end_stream();
    endtask

    task automatic run_phase(input logic [lsc_pkg::CFG_DATA_W-1:0] set_val,
                             input logic [lsc_pkg::CFG_DATA_W-1:0] offset_val,
                             input logic [lsc_pkg::CFG_DATA_W-1:0] ways_val,
                             input int unsigned n_items, input bit hold);
        drain();
        configure(set_val, offset_val, ways_val);
        if (hold) hold_req = 1'b1;
        run_random(n_items);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: two sets, 16-byte blocks, one way.
        send_address(64'h0);
        send_address(64'h0);
        send_address(64'hF);
        send_address(64'h10);
        send_address('1);
        send_address('1);
        send_address(64'h20);
        send_address(64'h8000_0000_0000_0000);
        send_address(64'h0);
        end_stream();

        // Two ways: fill the second way, hit the first, evict the older line twice, then hit.
        drain();
        configure(5'd1, 5'd4, 5'd2);
        send_address(64'h20);
        send_address(64'h0);
        send_address(64'h40);
        send_address(64'h20);
        send_address(64'h40);
        end_stream();

        // Zero bit counts and zero ways act as one.
        drain();
        cfg_write(CFG_SPARE, 5'h1F);
        configure(5'd0, 5'd0, 5'd0);
        send_address(64'h0);
        send_address(64'h2);
        send_address('1);
        send_address('1);
        end_stream();

        idle_on = 1'b1;
        run_phase(5'd2, 5'd4, 5'd4, 200, 1'b0);
        run_phase(5'd6, 5'd16, 5'd8, 200, 1'b1);
        run_phase(5'd0, 5'd0, 5'd0, 150, 1'b0);
        run_phase(5'd7, 5'd31, 5'd15, 150, 1'b0);
        run_phase(5'd3, 5'd5, 5'd8, 150, 1'b0);
        // Fewer ways in use: lines beyond keep their contents and come back later.
        run_phase(5'd3, 5'd5, 5'd2, 150, 1'b0);
        run_phase(5'd3, 5'd5, 5'd8, 150, 1'b0);
        run_phase(5'd1, 5'd1, 5'd3, 150, 1'b0);
        idle_on = 1'b0;
        run_phase(5'd4, 5'd7, 5'd6, 200, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_lookups.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== lru_set_assoc_cache_lookup_top.f =====
src/lsc_pkg.sv
src/lsc_ram.sv
src/lsc_split.sv
src/lsc_engine.sv
src/lru_set_assoc_cache_lookup_top.sv
src/lsc_checker.sv
dv/tb_top.sv
